// File: hw/rtl/bpq_pkg.sv
package bpq_pkg;

    // Widths and defaults
    localparam int VALUE_BITS         = 32;
    localparam int DEFAULT_DEPTH      = 16;
    localparam int DEFAULT_PRIO_BITS  = 8;
    localparam int STATUS_BITS        = 2;

    // Request kind, carried on the slave tuser
    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_REMOVE = 1'b1
    } t_req;

    // Result status, carried on the master tuser
    typedef enum logic [STATUS_BITS-1:0] {
        ST_DONE     = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } t_status;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctrl;

endpackage

// File: hw/rtl/bpq_cell.sv
// One slot of the sorted chain: hold, take the new entry, or take a neighbour's.
module bpq_cell #(
    parameter int PRIORITY_BITS = bpq_pkg::DEFAULT_PRIO_BITS
) (
    input  logic                          i_clk,
    input  bpq_pkg::t_cell_ctrl           i_ctrl,
    input  logic                          i_valid,
    input  logic [bpq_pkg::VALUE_BITS-1:0] i_new_value,
    input  logic [PRIORITY_BITS-1:0]      i_new_prio,
    input  logic                          i_left_take,
    input  logic [bpq_pkg::VALUE_BITS-1:0] i_left_value,
    input  logic [PRIORITY_BITS-1:0]      i_left_prio,
    input  logic [bpq_pkg::VALUE_BITS-1:0] i_right_value,
    input  logic [PRIORITY_BITS-1:0]      i_right_prio,
    output logic                          o_take,
    output logic [bpq_pkg::VALUE_BITS-1:0] o_value,
    output logic [PRIORITY_BITS-1:0]      o_prio
);

    logic [bpq_pkg::VALUE_BITS-1:0] r_value, n_value;
    logic [PRIORITY_BITS-1:0]       r_prio, n_prio;

    // New entry goes ahead of this slot when the slot is empty or weaker
    assign o_take = !i_valid || (r_prio < i_new_prio);

    always_comb begin
        n_value = r_value;
        n_prio  = r_prio;
        if (i_ctrl.ins && o_take) begin
            if (i_left_take) begin
                n_value = i_left_value;
                n_prio  = i_left_prio;
            end else begin
                n_value = i_new_value;
                n_prio  = i_new_prio;
            end
        end else if (i_ctrl.rem) begin
            n_value = i_right_value;
            n_prio  = i_right_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_prio  <= n_prio;
    end

    assign o_value = r_value;
    assign o_prio  = r_prio;

endmodule

// File: hw/rtl/bounded_priority_queue.sv
// Channel   | Dir | tdata (lowest bit up)                           | tuser
// ----------+-----+-------------------------------------------------+------------
// s_axis    | in  | item_value[31:0], item_priority, zero pad        | req_type
// m_axis    | out | removed_value[31:0], removed_priority, occupancy,| status
//           |     | zero pad                                         |
//
// One request per cycle: the whole chain of cells updates in the cycle the
// request is accepted, and the result lands in the output register at that edge.
// The rate is set by the output register: s_axis_tready falls only while a
// result is held and m_axis_tready is low.
// Reset (i_rst_n low, synchronous) empties the queue and drops any held result;
// the cell contents are left as they are and are ignored through the fill count.
module bounded_priority_queue #(
    parameter int DEPTH         = bpq_pkg::DEFAULT_DEPTH,
    parameter int PRIORITY_BITS = bpq_pkg::DEFAULT_PRIO_BITS,
    localparam int CW = $clog2(DEPTH + 1),
    localparam int IW = ((bpq_pkg::VALUE_BITS + PRIORITY_BITS + 7) / 8) * 8,
    localparam int OW = ((bpq_pkg::VALUE_BITS + PRIORITY_BITS + CW + 7) / 8) * 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [IW-1:0] s_axis_tdata,   // item_value, item_priority
    input  logic          s_axis_tuser,   // req_type
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [OW-1:0] m_axis_tdata,   // removed_value, removed_priority, occupancy
    output logic [bpq_pkg::STATUS_BITS-1:0] m_axis_tuser  // status
);

    localparam int VB = bpq_pkg::VALUE_BITS;

    // Request fields
    logic [VB-1:0]            w_value;
    logic [PRIORITY_BITS-1:0] w_prio;
    logic                     w_accept;
    logic                     w_full;
    logic                     w_empty;
    bpq_pkg::t_cell_ctrl      w_ctrl;

    // Fill count and result register
    logic [CW-1:0]            r_count, n_count;
    logic                     r_m_valid;
    bpq_pkg::t_status         r_status, n_status;
    logic [VB-1:0]            r_rv, n_rv;
    logic [PRIORITY_BITS-1:0] r_rp, n_rp;
    logic [CW-1:0]            r_occ;

    // Chain wiring
    logic [DEPTH-1:0]         w_cell_valid;
    logic [DEPTH-1:0]         w_take;
    logic [VB-1:0]            w_cv [DEPTH];
    logic [PRIORITY_BITS-1:0] w_cp [DEPTH];

    assign w_value = s_axis_tdata[VB-1:0];
    assign w_prio  = s_axis_tdata[VB +: PRIORITY_BITS];

    // Take a request whenever the output register is free or being drained
    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_full  = (r_count == CW'(DEPTH));
    assign w_empty = (r_count == '0);

    // Refused requests leave the chain untouched
    assign w_ctrl.ins = w_accept && (bpq_pkg::t_req'(s_axis_tuser) == bpq_pkg::REQ_INSERT)
                        && !w_full;
    assign w_ctrl.rem = w_accept && (bpq_pkg::t_req'(s_axis_tuser) == bpq_pkg::REQ_REMOVE)
                        && !w_empty;

    // Chain of cells, front (highest priority) at index 0
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                     w_lt;
        logic [VB-1:0]            w_lv, w_rv;
        logic [PRIORITY_BITS-1:0] w_lp, w_rp;

        assign w_cell_valid[g] = (r_count > CW'(g));

        if (g == 0) begin : g_head
            assign w_lt = 1'b0;
            assign w_lv = '0;
            assign w_lp = '0;
        end else begin : g_body
            assign w_lt = w_take[g-1];
            assign w_lv = w_cv[g-1];
            assign w_lp = w_cp[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_rv = '0;
            assign w_rp = '0;
        end else begin : g_mid
            assign w_rv = w_cv[g+1];
            assign w_rp = w_cp[g+1];
        end

        bpq_cell #(
            .PRIORITY_BITS (PRIORITY_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (w_ctrl),
            .i_valid       (w_cell_valid[g]),
            .i_new_value   (w_value),
            .i_new_prio    (w_prio),
            .i_left_take   (w_lt),
            .i_left_value  (w_lv),
            .i_left_prio   (w_lp),
            .i_right_value (w_rv),
            .i_right_prio  (w_rp),
            .o_take        (w_take[g]),
            .o_value       (w_cv[g]),
            .o_prio        (w_cp[g])
        );
    end

    // Next count and result fields
    always_comb begin
        n_count  = r_count;
        n_status = bpq_pkg::ST_DONE;
        n_rv     = '0;
        n_rp     = '0;
        unique case (bpq_pkg::t_req'(s_axis_tuser))
            bpq_pkg::REQ_INSERT: begin
                if (w_full) begin
                    n_status = bpq_pkg::ST_OVERFLOW;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            bpq_pkg::REQ_REMOVE: begin
                if (w_empty) begin
                    n_status = bpq_pkg::ST_EMPTY;
                end else begin
                    n_count = r_count - CW'(1);
                    n_rv    = w_cv[0];
                    n_rp    = w_cp[0];
                end
            end
            default: n_status = bpq_pkg::ST_DONE;
        endcase
    end

    // Control: fill count and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            if (w_accept) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Payload: load with each accepted request, hold while stalled
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_rv     <= n_rv;
            r_rp     <= n_rp;
            r_occ    <= n_count;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = OW'({r_occ, r_rp, r_rv});

endmodule

// File: hw/rtl/bpq_checker.sv
module bpq_checker #(
    parameter int DEPTH         = bpq_pkg::DEFAULT_DEPTH,
    parameter int PRIORITY_BITS = bpq_pkg::DEFAULT_PRIO_BITS,
    localparam int CW = $clog2(DEPTH + 1),
    localparam int OW = ((bpq_pkg::VALUE_BITS + PRIORITY_BITS + CW + 7) / 8) * 8
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          s_axis_tready,
    input logic          m_axis_tvalid,
    input logic          m_axis_tready,
    input logic [OW-1:0] m_axis_tdata,
    input logic [bpq_pkg::STATUS_BITS-1:0] m_axis_tuser
);

    localparam int VB = bpq_pkg::VALUE_BITS;

    logic [CW-1:0]                    w_occ;
    logic [VB+PRIORITY_BITS-1:0]      w_removed;

    assign w_occ           = m_axis_tdata[VB+PRIORITY_BITS +: CW];
    assign w_removed       = m_axis_tdata[VB+PRIORITY_BITS-1:0];

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Occupancy never passes the depth
    a_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_occ <= CW'(DEPTH)))
        else $error("occupancy beyond depth");

    // Overflow only when full, with nothing removed
    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == bpq_pkg::ST_OVERFLOW) |->
            (w_occ == CW'(DEPTH)) && (w_removed == '0))
        else $error("overflow status inconsistent");

    // Empty only when nothing held, with nothing removed
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == bpq_pkg::ST_EMPTY) |->
            (w_occ == '0) && (w_removed == '0))
        else $error("empty status inconsistent");

    // A request is refused only while a held result is stalled
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("request refused without backpressure");

endmodule

bind bounded_priority_queue bpq_checker #(
    .DEPTH         (DEPTH),
    .PRIORITY_BITS (PRIORITY_BITS)
) u_bpq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
